// File: src/cyclic_multi_alarm_timer_assert.svh
// Assertion macros shared by the alarm timer RTL.
`ifndef CYCLIC_MULTI_ALARM_TIMER_ASSERT_SVH
`define CYCLIC_MULTI_ALARM_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
`define CMAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CMAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/cmat_pkg.sv
package cmat_pkg;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned NUM_SLOTS  = 4;
    localparam int unsigned MAX_ALARMS = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // operation codes
    localparam func_t FUNC_CHECK   = 2'd0;
    localparam func_t FUNC_START   = 2'd1;
    localparam func_t FUNC_RESTART = 2'd2;

    // register indexes
    localparam cfg_idx_t CFG_ALARM_COUNT    = 3'd0;
    localparam cfg_idx_t CFG_INTERVAL_ZERO  = 3'd1;
    localparam cfg_idx_t CFG_INTERVAL_ONE   = 3'd2;
    localparam cfg_idx_t CFG_INTERVAL_TWO   = 3'd3;
    localparam cfg_idx_t CFG_INTERVAL_THREE = 3'd4;

    typedef struct packed {
        func_t              func;
        logic [TICK_W-1:0]  now_tick;
        logic [TICK_W-1:0]  start_offset;
    } req_t;

    typedef struct packed {
        logic               alarm_hit;
        logic [SLOT_W-1:0]  alarm_id;
        logic               at_start;
        logic               at_end;
    } rsp_t;

    typedef struct packed {
        cfg_idx_t           index;
        logic [TICK_W-1:0]  data;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_sel_full;
        logic save_end;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic check_div;
        logic div_busy;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// File: src/cmat_stream_if.sv
interface cmat_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/cmat_div.sv
`include "cyclic_multi_alarm_timer_assert.svh"

module cmat_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cmat_pkg::TICK_W-1:0]  dividend,
    input  logic [cmat_pkg::TICK_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [cmat_pkg::TICK_W-1:0]  remainder
);

    localparam int unsigned W     = cmat_pkg::TICK_W;
    localparam int unsigned STEP_W = $clog2(W + 1);

    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [W-1:0]      dvd_reg;
    logic [W-1:0]      dvs_reg;
    logic [W-1:0]      rem_reg;
    logic [W:0]        trial;
    logic [W-1:0]      rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= STEP_W'(W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign remainder = rem_reg;

    `CMAT_ASSERT(a_div_done_after_last, clk, rst_n, (cnt_reg == STEP_W'(1) && !start) |=> done_reg, "divider missed done")
    `CMAT_ASSERT(a_div_done_pulse, clk, rst_n, done_reg |=> !done_reg, "divider done longer than one cycle")
    `CMAT_ASSERT(a_div_rem_range, clk, rst_n, (done_reg && dvs_reg != '0) |-> (rem_reg < dvs_reg), "remainder not below divisor")

endmodule

// File: src/cmat_datapath.sv
module cmat_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmat_pkg::req_t       req_payload,
    input  logic                 cfg_valid,
    input  cmat_pkg::cfg_t       cfg_payload,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output cmat_pkg::rsp_t       rsp_payload,
    input  cmat_pkg::cmd_t       cmd,
    output cmat_pkg::stat_t      stat
);

    localparam int unsigned W      = cmat_pkg::TICK_W;
    localparam int unsigned CNT_W  = cmat_pkg::CNT_W;
    localparam int unsigned SLOT_W = cmat_pkg::SLOT_W;

    function automatic logic [CNT_W-1:0] wrap_index(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] c
    );
        logic [CNT_W-1:0] r;
        r = a;
        for (int i = 0; i < cmat_pkg::NUM_SLOTS; i++)
        begin
            if (r >= c)
            begin
                r = r - c;
            end
        end
        return r;
    endfunction

    // configuration
    logic [CNT_W-1:0]  count_reg;
    logic [W-1:0]      interval_reg [cmat_pkg::NUM_SLOTS];

    // architectural state
    logic [W-1:0]      start_time_reg;
    logic [SLOT_W-1:0] cur_reg;

    // captured request
    cmat_pkg::func_t   func_reg;
    logic [W-1:0]      now_reg;
    logic [W-1:0]      offset_reg;
    logic [W-1:0]      elapsed_reg;
    logic [W-1:0]      ival_reg;
    logic [CNT_W-1:0]  cnt_eff_reg;
    logic              at_start_reg;
    logic              end_zero_reg;

    // response register
    logic              rsp_valid_reg;
    cmat_pkg::rsp_t    rsp_reg;

    logic [CNT_W-1:0]  cnt_eff;
    logic [W-1:0]      div_rem;
    logic              div_busy;
    logic              div_done;
    logic [W-1:0]      divisor;
    logic [W-1:0]      start_time_next;
    logic [SLOT_W-1:0] cur_next;
    cmat_pkg::rsp_t    rsp_next;
    logic [SLOT_W-1:0] next_idx;
    logic              elapsed_zero;

    assign cnt_eff = (count_reg > CNT_W'(cmat_pkg::MAX_ALARMS))
                   ? CNT_W'(cmat_pkg::MAX_ALARMS) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < cmat_pkg::NUM_SLOTS; i++)
            begin
                interval_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_payload.index == cmat_pkg::CFG_ALARM_COUNT)
            begin
                count_reg <= cfg_payload.data[CNT_W-1:0];
            end
            else if (cfg_payload.index >= cmat_pkg::CFG_INTERVAL_ZERO
                  && cfg_payload.index <= cmat_pkg::CFG_INTERVAL_THREE)
            begin
                interval_reg[SLOT_W'(cfg_payload.index - cmat_pkg::CFG_INTERVAL_ZERO)]
                    <= cfg_payload.data;
            end
        end
    end

    // capture the request with the flags taken from the old state
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= req_payload.func;
            now_reg      <= req_payload.now_tick;
            offset_reg   <= req_payload.start_offset;
            elapsed_reg  <= req_payload.now_tick - start_time_reg;
            ival_reg     <= interval_reg[cur_reg];
            cnt_eff_reg  <= cnt_eff;
            at_start_reg <= (req_payload.now_tick == start_time_reg) && (cur_reg == '0);
        end
        if (cmd.save_end)
        begin
            end_zero_reg <= (div_rem == '0);
        end
    end

    assign divisor = cmd.div_sel_full ? ival_reg : ival_reg - 1'b1;

    cmat_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (elapsed_reg),
        .divisor   (divisor),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign elapsed_zero = (elapsed_reg == '0);
    assign next_idx     = SLOT_W'(wrap_index(CNT_W'(cur_reg) + 1'b1, cnt_eff_reg));

    always_comb
    begin
        start_time_next = start_time_reg;
        cur_next        = cur_reg;
        rsp_next        = '0;
        unique case (func_reg)
            cmat_pkg::FUNC_CHECK:
            begin
                rsp_next.at_start = at_start_reg;
                if (cnt_eff_reg != '0)
                begin
                    rsp_next.at_end = (ival_reg[W-1:1] == '0)
                                   || (!elapsed_zero && end_zero_reg);
                    if (!elapsed_reg[W-1])
                    begin
                        if (elapsed_zero)
                        begin
                            rsp_next.alarm_hit = 1'b1;
                        end
                        else if (ival_reg == '0 || div_rem == '0)
                        begin
                            start_time_next    = now_reg;
                            cur_next           = next_idx;
                            rsp_next.alarm_hit = 1'b1;
                            rsp_next.alarm_id  = next_idx;
                        end
                    end
                end
            end
            cmat_pkg::FUNC_START:
            begin
                start_time_next = now_reg + offset_reg;
            end
            cmat_pkg::FUNC_RESTART:
            begin
                start_time_next = now_reg + offset_reg;
                cur_next        = '0;
            end
            default:
            begin
                start_time_next = start_time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            cur_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                start_time_reg <= start_time_next;
                cur_reg        <= cur_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

    assign stat.check_div = (func_reg == cmat_pkg::FUNC_CHECK) && (cnt_eff_reg != '0);
    assign stat.div_busy  = div_busy;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

endmodule

// File: src/cmat_ctrl.sv
`include "cyclic_multi_alarm_timer_assert.svh"

module cmat_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  cmat_pkg::stat_t  stat,
    output cmat_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV_A,
        S_START_B,
        S_DIV_B,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.check_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_A;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV_A:
            begin
                if (stat.div_done)
                begin
                    cmd.save_end = 1'b1;
                    state_next   = S_START_B;
                end
            end
            S_START_B:
            begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_full = 1'b1;
                state_next       = S_DIV_B;
            end
            S_DIV_B:
            begin
                if (stat.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    `CMAT_ASSERT(a_ctrl_no_restart_busy, clk, rst_n, cmd.div_start |-> !stat.div_busy, "divider started while busy")
    `CMAT_ASSERT(a_ctrl_done_in_wait, clk, rst_n, stat.div_done |-> (state_reg == S_DIV_A || state_reg == S_DIV_B), "divider done outside a wait state")
    `CMAT_ASSERT(a_ctrl_one_at_a_time, clk, rst_n, (req_valid && req_ready) |=> !req_ready, "second request taken while one is in flight")

endmodule

// File: src/cyclic_multi_alarm_timer.sv
// Cyclic multi-alarm timer.
// Channels: req (sink) carries func, now_tick and start_offset; rsp (source)
// returns alarm_hit, alarm_id, at_start and at_end, one response per request;
// cfg (sink) writes alarm_count (index 0) and the four slot intervals
// (indexes 1 to 4). cfg is always ready; other indexes are dropped.
// Sequence: a start, restart, unused code or a check with alarms disabled
// goes from capture through a decide step to the final update. A check with
// alarms enabled runs two 32-bit remainders in turn on one bit-serial
// divider (one quotient bit per cycle) before the final update; the next
// request is taken only after that update.
// One request is in flight at a time. The response register parts the two
// sides: a new request is taken while the previous response waits, and only
// the final update stalls until rsp is free.
// Reset (rst_n low, asynchronous) clears the start time, alarm index, all
// configuration registers and the response valid.
module cyclic_multi_alarm_timer (
    input  logic           clk,
    input  logic           rst_n,
    cmat_stream_if.sink    req,
    cmat_stream_if.source  rsp,
    cmat_stream_if.sink    cfg
);

    cmat_pkg::cmd_t  cmd;
    cmat_pkg::stat_t stat;

    // accept every configuration write at once
    assign cfg.ready = 1'b1;

    // sequence capture, the two remainders and the final update
    cmat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold configuration, timer state, divider and response register
    cmat_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_payload (req.payload),
        .cfg_valid   (cfg.valid),
        .cfg_payload (cfg.payload),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_payload (rsp.payload),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
